// File: src/jkv_pkg.sv
// ----------------------------------------------------------------------------
// jkv_pkg
// Item types and character/kind constants shared by the JSON key/value
// extractor and its checker.
// ----------------------------------------------------------------------------
package jkv_pkg;

    // Fixed field widths
    localparam int KEY_LEN_BITS = 5;
    localparam int OFFSET_BITS  = 16;
    localparam int NEST_BITS    = 16;
    localparam int KIND_BITS    = 3;

    // Value kinds reported in value_kind
    localparam logic [KIND_BITS-1:0] KIND_NONE        = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_STRING      = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_LIST        = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_OBJECT      = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_NUMBER      = 3'd4;
    localparam logic [KIND_BITS-1:0] KIND_UNSUPPORTED = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [1:0] REG_KEY_LEN  = 2'd2;

    // Characters of interest
    localparam logic [7:0] CH_QUOTE  = 8'h22;  // "
    localparam logic [7:0] CH_LBRACK = 8'h5B;  // [
    localparam logic [7:0] CH_RBRACK = 8'h5D;  // ]
    localparam logic [7:0] CH_LBRACE = 8'h7B;  // {
    localparam logic [7:0] CH_RBRACE = 8'h7D;  // }
    localparam logic [7:0] CH_DOT    = 8'h2E;  // .
    localparam logic [7:0] CH_MINUS  = 8'h2D;  // -
    localparam logic [7:0] CH_ZERO   = 8'h30;  // 0
    localparam logic [7:0] CH_NINE   = 8'h39;  // 9

    // Input item: one text byte
    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } in_item_t;

    // Result item: one per text
    typedef struct packed {
        logic                   found;
        logic [KIND_BITS-1:0]   value_kind;
        logic [OFFSET_BITS-1:0] value_start;
        logic [OFFSET_BITS-1:0] value_stop;
        logic                   terminated;
    } out_item_t;

endpackage

// File: src/json_key_value_extractor.sv
// ----------------------------------------------------------------------------
// json_key_value_extractor
// Finds the first quoted occurrence of a configured key in a JSON byte
// stream and reports the kind and byte range of the value that follows.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_item carry one text byte per item; last_byte marks the
//   final byte of a text. m_valid/m_ready/m_item carry at most one result per
//   text: when the value ends, or with the final byte otherwise.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the key registers (index 0
//   key bytes 1..8, 1 key bytes 9..16, 2 key length); write only while idle.
// Timing:
//   One byte per cycle sustained while m_ready keeps the output register
//   drained. An item is captured in an input register, processed from there
//   (window compare and phase update) and its result lands in the output
//   register, which drives m_valid.
// Stall:
//   A waiting result holds m_item; the input register keeps accepting as
//   long as the output register is free or being drained in the same cycle.
// Reset:
//   aresetn (synchronous) empties both registers, returns the parser to
//   key search at offset zero, clears the window, and sets the key to
//   all-zero bytes with length 1. Each final byte also restarts the parser.
// ----------------------------------------------------------------------------
module json_key_value_extractor
    import jkv_pkg::*;
#(
    parameter int MAX_KEY       = 16,
    parameter int POSITION_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // byte stream
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_item,
    // results
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_item,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int WIN_DEPTH = MAX_KEY + 2;
    localparam int HIST      = MAX_KEY + 1;
    localparam int LW        = $clog2(MAX_KEY + 1) < 1 ? 1 : $clog2(MAX_KEY + 1);
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [NEST_BITS-1:0]     NEST_MAX = '1;

    typedef enum logic [7:0] {
        PH_SEARCH   = 8'b0000_0001,
        PH_SKIP     = 8'b0000_0010,
        PH_CLASSIFY = 8'b0000_0100,
        PH_STRING   = 8'b0000_1000,
        PH_LIST     = 8'b0001_0000,
        PH_OBJECT   = 8'b0010_0000,
        PH_NUMBER   = 8'b0100_0000,
        PH_DONE     = 8'b1000_0000
    } phase_t;

    // Configuration registers
    logic [63:0]             key_low_reg;
    logic [63:0]             key_high_reg;
    logic [KEY_LEN_BITS-1:0] key_len_reg;

    // Pipeline registers
    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;

    // Parser state
    logic [7:0]               recent_reg [HIST];
    logic [7:0]               recent_next [HIST];
    phase_t                   phase_reg, phase_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [NEST_BITS-1:0]     nest_reg, nest_next;
    logic [KIND_BITS-1:0]     kind_reg, kind_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;

    logic      proc;
    logic      emit;
    out_item_t res;

    // Handshakes
    assign proc      = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_item    = out_item_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= KEY_LEN_BITS'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LEN:  key_len_reg  <= cfg_data[KEY_LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Key match over the window, one candidate per key length
    logic [7:0]              win [WIN_DEPTH];
    logic [127:0]            key_all;
    logic [MAX_KEY:0]        match_vec;
    logic [KEY_LEN_BITS-1:0] len_eff;
    logic                    match;

    assign key_all = {key_high_reg, key_low_reg};
    assign len_eff = (key_len_reg > KEY_LEN_BITS'(MAX_KEY)) ?
                     KEY_LEN_BITS'(MAX_KEY) : key_len_reg;

    always_comb begin
        win[0] = in_item_reg.text_byte;
        for (int j = 0; j < HIST; j++) begin
            win[j+1] = recent_reg[j];
        end
        for (int l = 0; l <= MAX_KEY; l++) begin
            match_vec[l] = (win[0] == CH_QUOTE) && (win[l+1] == CH_QUOTE);
            for (int j = 1; j <= l; j++) begin
                if (win[j] != key_all[8*(l-j) +: 8]) begin
                    match_vec[l] = 1'b0;
                end
            end
        end
    end

    assign match = match_vec[len_eff[LW-1:0]];

    // Saturating offsets
    logic [POSITION_BITS:0]   sum1, sum2;
    logic [POSITION_BITS-1:0] len_now, pos_p2, st_clamp;

    assign sum1     = {1'b0, pos_reg} + (POSITION_BITS+1)'(1);
    assign sum2     = {1'b0, pos_reg} + (POSITION_BITS+1)'(2);
    assign len_now  = sum1[POSITION_BITS] ? POS_MAX : sum1[POSITION_BITS-1:0];
    assign pos_p2   = sum2[POSITION_BITS] ? POS_MAX : sum2[POSITION_BITS-1:0];
    assign st_clamp = (start_reg > len_now) ? len_now : start_reg;

    // Byte classification
    logic [7:0] b;
    logic       last;
    logic       is_num;
    logic [7:0] opener, closer;
    logic [NEST_BITS-1:0] nest_dec;

    assign b        = in_item_reg.text_byte;
    assign last     = in_item_reg.last_byte;
    assign is_num   = (b == CH_DOT) || (b >= CH_ZERO && b <= CH_NINE);
    assign opener   = (phase_reg == PH_LIST) ? CH_LBRACK : CH_LBRACE;
    assign closer   = (phase_reg == PH_LIST) ? CH_RBRACK : CH_RBRACE;
    assign nest_dec = (nest_reg != '0) ? nest_reg - NEST_BITS'(1) : '0;

    // Parser step for the byte in the input register
    always_comb begin
        recent_next = recent_reg;
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        nest_next   = nest_reg;
        kind_next   = kind_reg;
        start_next  = start_reg;
        emit        = 1'b0;
        res         = '0;

        case (phase_reg)
            PH_SEARCH: begin
                for (int j = 0; j < HIST; j++) begin
                    recent_next[j] = win[j];
                end
                if (match) begin
                    phase_next = PH_SKIP;
                    start_next = pos_p2;
                end
                if (last) begin
                    emit = 1'b1;
                    if (match) begin
                        res.found       = 1'b1;
                        res.value_start = OFFSET_BITS'(len_now);
                        res.value_stop  = OFFSET_BITS'(len_now);
                    end
                end
            end
            PH_SKIP: begin
                phase_next = PH_CLASSIFY;
                if (last) begin
                    emit            = 1'b1;
                    res.found       = 1'b1;
                    res.value_start = OFFSET_BITS'(len_now);
                    res.value_stop  = OFFSET_BITS'(len_now);
                end
            end
            PH_CLASSIFY: begin
                res.found      = 1'b1;
                res.value_stop = OFFSET_BITS'(len_now);
                res.value_start = OFFSET_BITS'(st_clamp);
                if (b == CH_QUOTE) begin
                    kind_next       = KIND_STRING;
                    start_next      = len_now;
                    phase_next      = PH_STRING;
                    res.value_start = OFFSET_BITS'(len_now);
                end else if (b == CH_LBRACK) begin
                    kind_next  = KIND_LIST;
                    nest_next  = NEST_BITS'(1);
                    phase_next = PH_LIST;
                end else if (b == CH_LBRACE) begin
                    kind_next  = KIND_OBJECT;
                    nest_next  = NEST_BITS'(1);
                    phase_next = PH_OBJECT;
                end else if (b == CH_MINUS || is_num) begin
                    kind_next  = KIND_NUMBER;
                    phase_next = PH_NUMBER;
                end else begin
                    kind_next  = KIND_UNSUPPORTED;
                    start_next = pos_reg;
                    phase_next = PH_DONE;
                end
                res.value_kind = kind_next;
                if (kind_next == KIND_UNSUPPORTED) begin
                    // empty value at the offending byte, sent at once
                    emit            = 1'b1;
                    res.value_start = OFFSET_BITS'(pos_reg);
                    res.value_stop  = OFFSET_BITS'(pos_reg);
                end else begin
                    emit = last;
                end
            end
            PH_STRING: begin
                res.found       = 1'b1;
                res.value_kind  = KIND_STRING;
                res.value_start = OFFSET_BITS'(st_clamp);
                if (b == CH_QUOTE) begin
                    emit           = 1'b1;
                    res.value_stop = OFFSET_BITS'(pos_reg);
                    res.terminated = 1'b1;
                    phase_next     = PH_DONE;
                end else begin
                    emit           = last;
                    res.value_stop = OFFSET_BITS'(len_now);
                end
            end
            PH_LIST, PH_OBJECT: begin
                res.found       = 1'b1;
                res.value_kind  = kind_reg;
                res.value_start = OFFSET_BITS'(st_clamp);
                res.value_stop  = OFFSET_BITS'(len_now);
                emit            = last;
                if (b == closer) begin
                    nest_next = nest_dec;
                    if (nest_dec == '0) begin
                        // brackets balanced: value ends here
                        emit           = 1'b1;
                        res.terminated = 1'b1;
                        phase_next     = PH_DONE;
                    end
                end else if (b == opener) begin
                    if (nest_reg != NEST_MAX) begin
                        nest_next = nest_reg + NEST_BITS'(1);
                    end
                end
            end
            PH_NUMBER: begin
                res.found       = 1'b1;
                res.value_kind  = KIND_NUMBER;
                res.value_start = OFFSET_BITS'(st_clamp);
                if (is_num) begin
                    emit           = last;
                    res.value_stop = OFFSET_BITS'(len_now);
                end else begin
                    emit           = 1'b1;
                    res.value_stop = OFFSET_BITS'(pos_reg);
                    res.terminated = 1'b1;
                    phase_next     = PH_DONE;
                end
            end
            default: begin
                // value already reported: wait for the final byte
            end
        endcase

        // End of text restarts the parser
        if (last) begin
            for (int j = 0; j < HIST; j++) begin
                recent_next[j] = '0;
            end
            phase_next = PH_SEARCH;
            pos_next   = '0;
            nest_next  = '0;
            kind_next  = KIND_NONE;
            start_next = '0;
        end else begin
            pos_next = len_now;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    // Parser state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < HIST; j++) begin
                recent_reg[j] <= '0;
            end
            phase_reg <= PH_SEARCH;
            pos_reg   <= '0;
            nest_reg  <= '0;
            kind_reg  <= KIND_NONE;
            start_reg <= '0;
        end else if (proc) begin
            recent_reg <= recent_next;
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            nest_reg   <= nest_next;
            kind_reg   <= kind_next;
            start_reg  <= start_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc) begin
            out_valid_reg <= emit;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && emit) begin
            out_item_reg <= res;
        end
    end

endmodule

// File: src/jkv_checker.sv
// ----------------------------------------------------------------------------
// jkv_checker
// Port-level checks on the result channel of the JSON key/value extractor.
// ----------------------------------------------------------------------------
module jkv_checker
    import jkv_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    // No result in the cycle after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result changed");

    // Key not found gives an empty result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.found |->
            m_item.value_kind == KIND_NONE && m_item.value_start == '0 &&
            m_item.value_stop == '0 && !m_item.terminated)
        else $error("missing key with non-empty result");

    // Only a followed value can terminate
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.terminated |->
            m_item.found && (m_item.value_kind == KIND_STRING ||
            m_item.value_kind == KIND_LIST || m_item.value_kind == KIND_OBJECT ||
            m_item.value_kind == KIND_NUMBER))
        else $error("terminated result with wrong kind");

    // Kind code within range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.value_kind <= KIND_UNSUPPORTED)
        else $error("value kind out of range");

endmodule

bind json_key_value_extractor jkv_checker u_jkv_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
